// ===== design/tea_block_cipher_unit_defines.svh =====
// assertion macros used by the checker module teabc_chk
`ifndef TEA_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define TEA_BLOCK_CIPHER_UNIT_DEFINES_SVH

// checked only outside reset
`define TEABC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define TEABC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/teabc_pkg.sv =====
package teabc_pkg;

   localparam int unsigned ROUNDS_DEFAULT = 32;
   localparam int unsigned WORD_W = 32;

   localparam logic [31:0] DELTA = 32'h9E37_79B9;

   localparam logic [31:0] KEY0_RESET = 32'h2175_DA3A;
   localparam logic [31:0] KEY1_RESET = 32'hB3DB_E2DB;
   localparam logic [31:0] KEY2_RESET = 32'h0149_B411;
   localparam logic [31:0] KEY3_RESET = 32'hD4EA_C6A5;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY0 = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY1 = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY2 = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY3 = 2'd3;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [31:0] z;
      logic [31:0] y;
   } blk_type;

   typedef struct packed {
      logic [31:0] k3;
      logic [31:0] k2;
      logic [31:0] k1;
      logic [31:0] k0;
   } key_type;

   // running sum after n additions of delta, modulo 2^32
   function automatic logic [31:0] tea_sum(input int unsigned n);
      logic [63:0] p;
      p = 64'(DELTA) * 64'(n);
      return p[31:0];
   endfunction

endpackage

// ===== design/teabc_skid.sv =====
module teabc_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  teabc_pkg::blk_type in_blk,
   output logic              in_ready,
   output logic              out_valid,
   output teabc_pkg::blk_type out_blk
);

   logic              skid_valid_ff;
   logic              skid_valid_in;
   teabc_pkg::blk_type skid_blk_ff;
   teabc_pkg::blk_type skid_blk_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = skid_valid_ff || in_valid;
   assign out_blk   = skid_valid_ff ? skid_blk_ff : in_blk;

   always_comb begin
      skid_valid_in = skid_valid_ff;
      skid_blk_in   = skid_blk_ff;
      if (enable) begin
         skid_valid_in = 1'b0;
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_blk_in   = in_blk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
      skid_blk_ff <= skid_blk_in;
   end

endmodule

// ===== design/teabc_stage.sv =====
module teabc_stage #(
   parameter logic [31:0] SUM_ENC = teabc_pkg::DELTA,
   parameter logic [31:0] SUM_DEC = teabc_pkg::DELTA,
   parameter bit          ODD     = 1'b0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  teabc_pkg::blk_type in_blk,
   input  teabc_pkg::key_type key,
   output logic              out_valid,
   output teabc_pkg::blk_type out_blk
);

   logic              valid_ff;
   logic              valid_in;
   teabc_pkg::blk_type blk_ff;
   teabc_pkg::blk_type blk_in;

   logic        upd_z;
   logic [31:0] src;
   logic [31:0] tgt;
   logic [31:0] ka;
   logic [31:0] kb;
   logic [31:0] sum;
   logic [31:0] mix;
   logic [31:0] res;

   // encrypt updates y then z, decrypt updates z then y
   always_comb begin
      upd_z = ODD ^ (in_blk.cmd == teabc_pkg::CMD_DECRYPT);
      src   = upd_z ? in_blk.y : in_blk.z;
      tgt   = upd_z ? in_blk.z : in_blk.y;
      ka    = upd_z ? key.k2 : key.k0;
      kb    = upd_z ? key.k3 : key.k1;
      sum   = (in_blk.cmd == teabc_pkg::CMD_DECRYPT) ? SUM_DEC : SUM_ENC;
      mix   = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
      res   = (in_blk.cmd == teabc_pkg::CMD_DECRYPT) ? (tgt - mix) : (tgt + mix);
      blk_in = in_blk;
      if (upd_z) begin
         blk_in.z = res;
      end else begin
         blk_in.y = res;
      end
      valid_in = enable ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         blk_ff <= blk_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_blk   = blk_ff;

endmodule

// ===== design/tea_block_cipher_unit.sv =====
// TEA block cipher engine, 64-bit block, 128-bit key.
// req channel: req_tdata = {word_high, word_low}, req_tuser = cmd
// (0 encrypt, 1 decrypt). rsp channel: rsp_tdata = {out_high, out_low}.
// csr port: csr_we writes csr_wdata into key word csr_addr (0..3) at the
// clock edge; write keys only while no item is in flight.
// a result moves through the half-round stage registers in order and shows
// on rsp_tvalid from the last one; a stall holds it where it is.
// throughput: one item per cycle unless stalled; each half-round is one
// register stage, 2*ROUNDS stages in all, the last one drives the rsp channel.
// stall: while rsp_tvalid is high and rsp_tready low the whole pipeline
// holds; one more item is taken into an input skid register, then
// req_tready drops until the stall clears.
// reset: synchronous; empties the pipeline and skid register and loads
// the fixed default key.
module tea_block_cipher_unit #(
   parameter int unsigned ROUNDS = teabc_pkg::ROUNDS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [63:0]                        req_tdata,   // word_low, word_high
   input  logic                               req_tuser,   // cmd
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [63:0]                        rsp_tdata,   // out_low, out_high
   input  logic                               csr_we,
   input  logic [teabc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [teabc_pkg::WORD_W-1:0]       csr_wdata
);

   localparam int unsigned NSTAGE = 2 * ROUNDS;

   teabc_pkg::key_type key_ff;
   teabc_pkg::key_type key_in;

   logic               enable;
   teabc_pkg::blk_type req_blk;
   logic               stage_valid [0:NSTAGE];
   teabc_pkg::blk_type stage_blk   [0:NSTAGE];

   always_comb begin
      key_in = key_ff;
      if (csr_we) begin
         case (csr_addr)
            teabc_pkg::CSR_KEY0: key_in.k0 = csr_wdata;
            teabc_pkg::CSR_KEY1: key_in.k1 = csr_wdata;
            teabc_pkg::CSR_KEY2: key_in.k2 = csr_wdata;
            teabc_pkg::CSR_KEY3: key_in.k3 = csr_wdata;
            default: key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff.k0 <= teabc_pkg::KEY0_RESET;
         key_ff.k1 <= teabc_pkg::KEY1_RESET;
         key_ff.k2 <= teabc_pkg::KEY2_RESET;
         key_ff.k3 <= teabc_pkg::KEY3_RESET;
      end else begin
         key_ff <= key_in;
      end
   end

   assign enable      = !stage_valid[NSTAGE] || rsp_tready;
   assign req_blk.cmd = req_tuser;
   assign req_blk.y   = req_tdata[31:0];
   assign req_blk.z   = req_tdata[63:32];

   teabc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_tvalid),
      .in_blk    (req_blk),
      .in_ready  (req_tready),
      .out_valid (stage_valid[0]),
      .out_blk   (stage_blk[0])
   );

   for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
      localparam int unsigned RND = s / 2;
      teabc_stage #(
         .SUM_ENC (teabc_pkg::tea_sum(RND + 1)),
         .SUM_DEC (teabc_pkg::tea_sum(ROUNDS - RND)),
         .ODD     (bit'(s % 2))
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (stage_valid[s]),
         .in_blk    (stage_blk[s]),
         .key       (key_ff),
         .out_valid (stage_valid[s+1]),
         .out_blk   (stage_blk[s+1])
      );
   end

   assign rsp_tvalid = stage_valid[NSTAGE];
   assign rsp_tdata  = {stage_blk[NSTAGE].z, stage_blk[NSTAGE].y};

endmodule

// ===== design/teabc_chk.sv =====
`include "tea_block_cipher_unit_defines.svh"

module teabc_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   `TEABC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp item changed while stalled")
   `TEABC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid && req_tready, "pipeline not empty after reset")
   `TEABC_ASSERT(a_ready_only_on_stall, clock, reset, !req_tready |-> $past(rsp_tvalid && !rsp_tready), "req_tready low without rsp stall")

endmodule

bind tea_block_cipher_unit teabc_chk u_teabc_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned NUM_ROUNDS   = teabc_pkg::ROUNDS_DEFAULT;
   localparam int unsigned PIPE_LATENCY = 2 * NUM_ROUNDS;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   typedef struct {
      logic [31:0] out_low;
      logic [31:0] out_high;
   } cipher_block_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // word_low, word_high
   logic        req_tuser = 1'b0; // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // out_low, out_high
   logic                             csr_we = 1'b0;
   logic [teabc_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [teabc_pkg::WORD_W-1:0]     csr_wdata = '0;

   teabc_pkg::key_type cur_key;
   cipher_block_type   cipher_out_q[$];
   int unsigned        error_count = 0;
   int unsigned        cycle_count = 0;
   int unsigned        rsp_stall_left = 0;
   int unsigned        hold_off_cycles = 0;
   bit                 tx_idle_on = 1'b0;
   bit                 rx_idle_on = 1'b0;

   tea_block_cipher_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [31:0] half_mix(logic [31:0] v, logic [31:0] s,
                                            logic [31:0] ka, logic [31:0] kb);
      return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
   endfunction

   function automatic cipher_block_type tea_predict(logic cmd, logic [31:0] y,
                                                    logic [31:0] z);
      cipher_block_type r;
      logic [31:0]      s;
      s = '0;
      if (cmd == teabc_pkg::CMD_ENCRYPT) begin
         for (int i = 0; i < NUM_ROUNDS; i++) begin
            s += teabc_pkg::DELTA;
            y += half_mix(z, s, cur_key.k0, cur_key.k1);
            z += half_mix(y, s, cur_key.k2, cur_key.k3);
         end
      end else begin
         for (int i = 0; i < NUM_ROUNDS; i++) s += teabc_pkg::DELTA;
         for (int i = 0; i < NUM_ROUNDS; i++) begin
            z -= half_mix(y, s, cur_key.k2, cur_key.k3);
            y -= half_mix(z, s, cur_key.k0, cur_key.k1);
            s -= teabc_pkg::DELTA;
         end
      end
      r.out_low  = y;
      r.out_high = z;
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      cipher_block_type exp_blk;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_stall_left = rx_idle_on ? $urandom_range(0, 4) : 0;
         if (cipher_out_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item, expected none, actual %h", $time, rsp_tdata);
         end else begin
            exp_blk = cipher_out_q.pop_front();
            if (rsp_tdata[31:0] !== exp_blk.out_low) begin
               error_count++;
               $display("%0t: out_low mismatch, expected %h, actual %h",
                        $time, exp_blk.out_low, rsp_tdata[31:0]);
            end
            if (rsp_tdata[63:32] !== exp_blk.out_high) begin
               error_count++;
               $display("%0t: out_high mismatch, expected %h, actual %h",
                        $time, exp_blk.out_high, rsp_tdata[63:32]);
            end
         end
      end
   end

   // receiver ready
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles--;
         end else if (rsp_stall_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_block(logic cmd, logic [31:0] y, logic [31:0] z);
      int unsigned gap;
      gap = tx_idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      cipher_out_q.push_back(tea_predict(cmd, y, z));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (cipher_out_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_key(logic [teabc_pkg::CSR_ADDR_W-1:0] addr, logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (addr)
         teabc_pkg::CSR_KEY0: cur_key.k0 = value;
         teabc_pkg::CSR_KEY1: cur_key.k1 = value;
         teabc_pkg::CSR_KEY2: cur_key.k2 = value;
         teabc_pkg::CSR_KEY3: cur_key.k3 = value;
         default: ;
      endcase
   endtask

   task automatic program_key(logic [31:0] k0, logic [31:0] k1,
                              logic [31:0] k2, logic [31:0] k3);
      write_key(teabc_pkg::CSR_KEY0, k0);
      write_key(teabc_pkg::CSR_KEY1, k1);
      write_key(teabc_pkg::CSR_KEY2, k2);
      write_key(teabc_pkg::CSR_KEY3, k3);
   endtask

   function automatic logic [31:0] rand_key_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] rand_half();
      case ($urandom_range(0, 15))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   task automatic test_default_key();
      send_block(teabc_pkg::CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
      send_block(teabc_pkg::CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000);
      send_block(teabc_pkg::CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(teabc_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(teabc_pkg::CMD_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_block(teabc_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_block(teabc_pkg::CMD_ENCRYPT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      send_block(teabc_pkg::CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000);
      wait_for_results();
   endtask

   task automatic test_key_extremes();
      program_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_block(teabc_pkg::CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
      send_block(teabc_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(teabc_pkg::CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
      send_block(teabc_pkg::CMD_DECRYPT, 32'h1234_5678, 32'h9ABC_DEF0);
      wait_for_results();
      program_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(teabc_pkg::CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
      send_block(teabc_pkg::CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000);
      send_block(teabc_pkg::CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(teabc_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
      wait_for_results();
      program_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_block(teabc_pkg::CMD_ENCRYPT, 32'hDEAD_BEEF, 32'h0123_4567);
      send_block(teabc_pkg::CMD_DECRYPT, 32'hDEAD_BEEF, 32'h0123_4567);
      wait_for_results();
   endtask

   task automatic test_random_blocks();
      logic [31:0] y;
      for (int phase = 0; phase < 12; phase++) begin
         if (phase > 0)
            program_key(rand_key_word(), rand_key_word(), rand_key_word(), rand_key_word());
         tx_idle_on = (phase == 0) ? 1'b0 : 1'($urandom_range(0, 1));
         rx_idle_on = (phase == 0) ? 1'b0 : 1'($urandom_range(0, 1));
         for (int n = 0; n < 130; n++) begin
            y = rand_half();
            // pause the sender now and then until the pipeline is empty
            if ($urandom_range(0, 99) == 0) wait_for_results();
            send_block($urandom_range(0, 1) ? teabc_pkg::CMD_DECRYPT : teabc_pkg::CMD_ENCRYPT,
                       y, rand_half());
         end
         wait_for_results();
      end
   endtask

   task automatic test_backpressure();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b1;
      @(posedge clock);
      hold_off_cycles = 300;
      for (int n = 0; n < 140; n++)
         send_block($urandom_range(0, 1) ? teabc_pkg::CMD_DECRYPT : teabc_pkg::CMD_ENCRYPT,
                    rand_half(), rand_half());
      wait_for_results();
   endtask

   initial begin
      cur_key.k0 = teabc_pkg::KEY0_RESET;
      cur_key.k1 = teabc_pkg::KEY1_RESET;
      cur_key.k2 = teabc_pkg::KEY2_RESET;
      cur_key.k3 = teabc_pkg::KEY3_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_key();
      test_key_extremes();
      test_random_blocks();
      test_backpressure();

      wait_for_results();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
